### design/sfe_pkg.sv
package sfe_pkg;

    localparam int IBITS = 30;
    localparam int FRAC_BITS_DEF = 16;

    localparam longint QL = 64'sd1 << IBITS;
    localparam logic [IBITS:0] QONE = 31'd1 << IBITS;
    localparam logic [62:0] QHALF = 63'd1 << (IBITS - 1);
    localparam logic [IBITS:0] SEG_EDGE = 31'd805306368;
    localparam logic signed [31:0] END0_SQ = 32'sd603979776;
    localparam logic signed [31:0] QONE_S = 32'sd1 << IBITS;

    localparam logic signed [31:0] NUM_COEF [2][5] = '{
        '{32'((8203343 * QL + 50000000) / 100000000),
          -32'((3644705 * QL + 5000000) / 10000000),
          32'((6278660 * QL + 5000000) / 10000000),
          -32'((5335581 * QL + 5000000) / 10000000),
          32'((2312756 * QL + 5000000) / 10000000)},
        '{32'((4028559 * QL + 500000000) / 1000000000),
          -32'((3697768 * QL + 50000000) / 100000000),
          32'((1021332 * QL + 5000000) / 10000000),
          -32'((1201436 * QL + 5000000) / 10000000),
          32'((6412774 * QL + 50000000) / 100000000)}
    };

    localparam logic signed [31:0] DEN_COEF [2][3] = '{
        '{QONE_S,
          32'((8212018 * QL + 5000000) / 10000000),
          32'((2078043 * QL + 5000000) / 10000000)},
        '{QONE_S,
          32'((9599102 * QL + 5000000) / 10000000),
          32'((2918724 * QL + 5000000) / 10000000)}
    };

    typedef enum logic [1:0] {
        CLS_ZERO,
        CLS_ONE,
        CLS_DIV
    } sfe_cls_t;

    typedef struct packed {
        logic               valid;
        logic               oor;
        logic               seg;
        logic [IBITS:0]     nusq;
        logic signed [31:0] d;
        logic signed [31:0] top;
        logic signed [31:0] bot;
    } sfe_poly_t;

    typedef struct packed {
        logic               valid;
        logic               oor;
        logic               seg;
        logic [IBITS:0]     nusq;
        logic signed [31:0] d;
        logic signed [31:0] bot;
        logic               top_neg;
        logic [61:0]        top_prod;
        logic               bot_neg;
        logic [61:0]        bot_prod;
    } sfe_prod_t;

    typedef struct packed {
        logic           valid;
        logic           oor;
        sfe_cls_t       cls;
        logic [IBITS:0] nusq;
        logic [30:0]    ub;
        logic [30:0]    rem;
        logic [30:0]    low;
        logic [30:0]    q;
    } sfe_div_t;

    function automatic logic [30:0] mag31(input logic signed [31:0] a);
        logic [31:0] m;
        m = a[31] ? 32'(-a) : 32'(a);
        return m[30:0];
    endfunction

    function automatic logic signed [31:0] qround(input logic [61:0] prod, input logic neg);
        logic [62:0] s;
        logic signed [31:0] r;
        s = {1'b0, prod} + QHALF;
        r = $signed(s[61:30]);
        return neg ? -r : r;
    endfunction

endpackage

### design/spheroidal_function_eval.sv
// Spheroidal gridding function (m = 6, alpha = 1) evaluator. Each transfer on
// the s_ side carries a distance nu in unsigned Q1.FRAC_BITS; each transfer on
// the m_ side returns psi(nu) and the weight (1 - nu^2) * psi(nu), both
// Q1.FRAC_BITS and at most 1.0, plus an out-of-range flag on m_tuser for
// nu > 1.0 (results zero). One item is taken every cycle unless a stalled
// m_tready holds the whole pipeline, which runs through the squaring stages,
// four two-stage Horner steps and a 31-stage one-bit-per-stage divider.
module spheroidal_function_eval #(
    parameter int FRAC_BITS = sfe_pkg::FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // nu_distance
    input  logic [((FRAC_BITS + 8) / 8) * 8 - 1:0] s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // sph_value, grid_weight
    output logic [((2 * FRAC_BITS + 9) / 8) * 8 - 1:0] m_tdata,
    // out_of_range
    output logic                                   m_tuser
);
    import sfe_pkg::*;

    localparam int W = FRAC_BITS + 1;
    localparam int OW = ((2 * FRAC_BITS + 9) / 8) * 8;
    localparam int S = IBITS - FRAC_BITS;
    localparam logic [31:0] RND = (32'd1 << S) >> 1;
    localparam logic [W-1:0] FONE = W'(1) << FRAC_BITS;

    logic en;

    logic           v0_reg, oor0_reg;
    logic [W-1:0]   nu_reg;
    logic           v1_reg, oor1_reg, seg1_reg;
    logic [61:0]    sq_reg;
    logic [IBITS:0] nu30;
    logic [62:0]    sq_sum;
    logic [IBITS:0] nusq;

    sfe_poly_t poly_in_reg, poly_out;
    sfe_div_t  div_in_next, div_in_reg, div_out;

    logic           v4_reg, oor4_reg;
    logic [IBITS:0] val_reg, val_next;
    logic [61:0]    wprod_reg;
    logic [62:0]    w_sum;
    logic [31:0]    sph_r, w_r;

    logic           out_valid_reg;
    logic [OW-1:0]  out_data_reg;
    logic           out_oor_reg;

    assign en = !out_valid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nu_reg   <= s_tdata[W-1:0];
            oor0_reg <= s_tdata[W-1:0] > FONE;
        end
    end

    assign nu30 = (IBITS + 1)'(nu_reg) << S;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg   <= nu30 * nu30;
            seg1_reg <= nu30 >= SEG_EDGE;
            oor1_reg <= oor0_reg;
        end
    end

    assign sq_sum = {1'b0, sq_reg} + QHALF;
    assign nusq = sq_sum[60:30];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_in_reg <= '0;
        end else if (en) begin
            poly_in_reg.valid <= v1_reg;
            poly_in_reg.oor   <= oor1_reg;
            poly_in_reg.seg   <= seg1_reg;
            poly_in_reg.nusq  <= nusq;
            poly_in_reg.d     <= $signed({1'b0, nusq}) - (seg1_reg ? QONE_S : END0_SQ);
            poly_in_reg.top   <= '0;
            poly_in_reg.bot   <= '0;
        end
    end

    sfe_poly u_poly (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_stage (poly_in_reg),
        .out_stage(poly_out)
    );

    always_comb begin
        logic [30:0] ut;
        logic [30:0] ub;
        logic [61:0] num;
        ut = mag31(poly_out.top);
        ub = mag31(poly_out.bot);
        num = {ut, 31'd0} >> 1;
        num = num + 62'(ub >> 1);
        div_in_next.valid = poly_out.valid;
        div_in_next.oor   = poly_out.oor;
        div_in_next.nusq  = poly_out.nusq;
        div_in_next.ub    = ub;
        div_in_next.rem   = num[61:31];
        div_in_next.low   = num[30:0];
        div_in_next.q     = '0;
        if (poly_out.bot == 0 || poly_out.top == 0 || poly_out.top[31] != poly_out.bot[31]) begin
            div_in_next.cls = CLS_ZERO;
        end else if (ut >= ub) begin
            div_in_next.cls = CLS_ONE;
        end else begin
            div_in_next.cls = CLS_DIV;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_in_reg <= '0;
        end else if (en) begin
            div_in_reg <= div_in_next;
        end
    end

    sfe_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_stage (div_in_reg),
        .out_stage(div_out)
    );

    always_comb begin
        case (div_out.cls)
            CLS_ZERO: val_next = '0;
            CLS_ONE:  val_next = QONE;
            CLS_DIV:  val_next = (div_out.q > QONE) ? QONE : div_out.q;
            default:  val_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= div_out.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            oor4_reg  <= div_out.oor;
            val_reg   <= val_next;
            wprod_reg <= (QONE - div_out.nusq) * val_next;
        end
    end

    assign w_sum = {1'b0, wprod_reg} + QHALF;
    assign sph_r = (32'(val_reg) + RND) >> S;
    assign w_r   = (32'(w_sum[60:30]) + RND) >> S;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_oor_reg  <= oor4_reg;
            out_data_reg <= oor4_reg ? '0 : OW'({w_r[W-1:0], sph_r[W-1:0]});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_oor_reg;

endmodule

### design/sfe_poly.sv
module sfe_poly (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  sfe_pkg::sfe_poly_t in_stage,
    output sfe_pkg::sfe_poly_t out_stage
);
    import sfe_pkg::*;

    localparam int STEPS = 4;

    sfe_poly_t acc_in  [STEPS];
    sfe_prod_t prod_next [STEPS];
    sfe_prod_t prod_reg  [STEPS];
    sfe_poly_t acc_next  [STEPS];
    sfe_poly_t acc_reg   [STEPS];

    always_comb begin
        acc_in[0] = in_stage;
        acc_in[0].top = NUM_COEF[in_stage.seg][4];
        acc_in[0].bot = DEN_COEF[in_stage.seg][2];
    end

    for (genvar j = 0; j < STEPS; j++) begin : g_step
        if (j > 0) begin : g_link
            assign acc_in[j] = acc_reg[j-1];
        end

        always_comb begin
            prod_next[j].valid    = acc_in[j].valid;
            prod_next[j].oor      = acc_in[j].oor;
            prod_next[j].seg      = acc_in[j].seg;
            prod_next[j].nusq     = acc_in[j].nusq;
            prod_next[j].d        = acc_in[j].d;
            prod_next[j].bot      = acc_in[j].bot;
            prod_next[j].top_neg  = acc_in[j].top[31] != acc_in[j].d[31];
            prod_next[j].top_prod = mag31(acc_in[j].top) * mag31(acc_in[j].d);
            prod_next[j].bot_neg  = acc_in[j].bot[31] != acc_in[j].d[31];
            prod_next[j].bot_prod = mag31(acc_in[j].bot) * mag31(acc_in[j].d);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                prod_reg[j] <= '0;
            end else if (en) begin
                prod_reg[j] <= prod_next[j];
            end
        end

        always_comb begin
            acc_next[j].valid = prod_reg[j].valid;
            acc_next[j].oor   = prod_reg[j].oor;
            acc_next[j].seg   = prod_reg[j].seg;
            acc_next[j].nusq  = prod_reg[j].nusq;
            acc_next[j].d     = prod_reg[j].d;
            acc_next[j].top   = qround(prod_reg[j].top_prod, prod_reg[j].top_neg)
                                + NUM_COEF[prod_reg[j].seg][3-j];
            if (j < 2) begin
                acc_next[j].bot = qround(prod_reg[j].bot_prod, prod_reg[j].bot_neg)
                                  + DEN_COEF[prod_reg[j].seg][(j == 0) ? 1 : 0];
            end else begin
                acc_next[j].bot = prod_reg[j].bot;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                acc_reg[j] <= '0;
            end else if (en) begin
                acc_reg[j] <= acc_next[j];
            end
        end
    end

    assign out_stage = acc_reg[STEPS-1];

endmodule

### design/sfe_div.sv
module sfe_div (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  sfe_pkg::sfe_div_t in_stage,
    output sfe_pkg::sfe_div_t out_stage
);
    import sfe_pkg::*;

    localparam int QBITS = 31;

    sfe_div_t stage_in   [QBITS];
    sfe_div_t stage_next [QBITS];
    sfe_div_t stage_reg  [QBITS];

    assign stage_in[0] = in_stage;

    for (genvar i = 0; i < QBITS; i++) begin : g_bit
        logic [31:0] r2;
        logic        ge;

        if (i > 0) begin : g_link
            assign stage_in[i] = stage_reg[i-1];
        end

        always_comb begin
            r2 = {stage_in[i].rem, stage_in[i].low[30]};
            ge = r2 >= {1'b0, stage_in[i].ub};
            stage_next[i] = stage_in[i];
            stage_next[i].rem = ge ? 31'(r2 - {1'b0, stage_in[i].ub}) : r2[30:0];
            stage_next[i].low = {stage_in[i].low[29:0], 1'b0};
            stage_next[i].q   = {stage_in[i].q[29:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                stage_reg[i] <= '0;
            end else if (en) begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    assign out_stage = stage_reg[QBITS-1];

endmodule

### sim/sfe_checker.sv
module sfe_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tuser,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  FB   = 16;
    localparam int  QB   = 30;
    localparam longint ONE30 = 64'sd1 << QB;
    localparam longint unsigned HALF30 = 64'd1 << (QB - 1);

    typedef struct {
        logic [16:0] sph;
        logic [16:0] wgt;
        logic        oor;
    } psi_res_t;

    psi_res_t psi_q[$];
    longint   num_c [2][5];
    longint   den_c [2][3];

    function automatic longint qfix(longint m, longint d);
        return (m * ONE30 + d / 2) / d;
    endfunction

    function automatic longint unsigned absval(longint a);
        return (a < 0) ? longint'(-a) : a;
    endfunction

    function automatic longint fxmul(longint a, longint b);
        longint unsigned r;
        r = (absval(a) * absval(b) + HALF30) >> QB;
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic psi_res_t psi_eval(logic [16:0] nu_in);
        psi_res_t r;
        longint unsigned nu30, nusq, val, w, ut, ub;
        longint d, top, bot;
        int seg;
        r.oor = 1'b0;
        if (nu_in > 17'd65536) begin
            r.sph = '0;
            r.wgt = '0;
            r.oor = 1'b1;
            return r;
        end
        nu30 = longint'(nu_in) << (QB - FB);
        nusq = (nu30 * nu30 + HALF30) >> QB;
        seg = (nu30 < 64'd805306368) ? 0 : 1;
        d = longint'(nusq) - (seg == 0 ? 64'sd603979776 : ONE30);
        top = num_c[seg][4];
        for (int k = 3; k >= 0; k--) top = fxmul(top, d) + num_c[seg][k];
        bot = den_c[seg][2];
        for (int k = 1; k >= 0; k--) bot = fxmul(bot, d) + den_c[seg][k];
        val = 0;
        if (bot != 0 && top != 0 && ((top < 0) == (bot < 0))) begin
            ut = absval(top);
            ub = absval(bot);
            if (ut >= ub) val = ONE30;
            else val = ((ut << QB) + ub / 2) / ub;
        end
        if (val > ONE30) val = ONE30;
        w = ((ONE30 - nusq) * val + HALF30) >> QB;
        r.sph = 17'((val + (64'd1 << 13)) >> 14);
        r.wgt = 17'((w + (64'd1 << 13)) >> 14);
        return r;
    endfunction

    initial begin
        errors = 0;
        num_c[0] = '{qfix(8203343, 100000000), -qfix(3644705, 10000000),
                     qfix(6278660, 10000000), -qfix(5335581, 10000000),
                     qfix(2312756, 10000000)};
        num_c[1] = '{qfix(4028559, 1000000000), -qfix(3697768, 100000000),
                     qfix(1021332, 10000000), -qfix(1201436, 10000000),
                     qfix(6412774, 100000000)};
        den_c[0] = '{ONE30, qfix(8212018, 10000000), qfix(2078043, 10000000)};
        den_c[1] = '{ONE30, qfix(9599102, 10000000), qfix(2918724, 10000000)};
    end

    assign pending = psi_q.size();

    always @(posedge aclk) begin
        psi_res_t e;
        if (aresetn) begin
            if (s_tvalid && s_tready) psi_q.push_back(psi_eval(s_tdata[16:0]));
            if (m_tvalid && m_tready) begin
                if (psi_q.size() == 0) begin
                    $error("unexpected result transfer %h", m_tdata);
                    errors++;
                end else begin
                    e = psi_q.pop_front();
                    if (m_tdata[16:0] !== e.sph) begin
                        $error("sph_value expected %0d actual %0d", e.sph, m_tdata[16:0]);
                        errors++;
                    end
                    if (m_tdata[33:17] !== e.wgt) begin
                        $error("grid_weight expected %0d actual %0d", e.wgt, m_tdata[33:17]);
                        errors++;
                    end
                    if (m_tuser !== e.oor) begin
                        $error("out_of_range expected %0d actual %0d", e.oor, m_tuser);
                        errors++;
                    end
                end
            end
        end
    end
endmodule

### sim/tb_spheroidal_function_eval.sv
module tb_spheroidal_function_eval;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tuser;
    int          errors;
    int          pending;
    int          tx_idle;
    int          rx_idle;
    int          cycles;
    logic        rx_hold;
    logic        hold_go;

    spheroidal_function_eval dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    sfe_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .errors(errors), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        tx_idle  = 18;
        rx_idle  = 81;
        rx_hold  = 1'b0;
        hold_go  = 1'b0;
        cycles   = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge aclk)
        m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle);

    initial begin
        wait (hold_go);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    task automatic send_nu(logic [16:0] nu);
        while ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, nu};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [16:0] rand_nu();
        int sel;
        sel = $urandom_range(99);
        if (sel < 75) return 17'($urandom_range(65536));
        if (sel < 85) return 17'($urandom_range(49152 + 64, 49152 - 64));
        if (sel < 90) return 17'($urandom_range(65536, 65536 - 32));
        return 17'($urandom_range(131071, 65537));
    endfunction

    initial begin
        logic [16:0] directed [14];
        directed = '{17'd0, 17'd1, 17'd2, 17'd32768, 17'd49151, 17'd49152,
                     17'd49153, 17'd65535, 17'd65536, 17'd65537,
                     17'd98304, 17'd131071, 17'h0AAAA, 17'h15555};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed[i]) send_nu(directed[i]);
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle = (phase == 0) ? 18 : (phase == 1) ? 81 : 0;
            rx_idle = (phase == 0) ? 81 : (phase == 1) ? 18 : 0;
            if (phase == 2) hold_go = 1'b1;
            repeat (230) send_nu(rand_nu());
        end
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
